/* sv/lbs2d_pkg.sv */
// Shared constants and types for the 2D skinning engine.
// No dependencies; used by lbs2d_coef_ram and linear_blend_skinning_2d_top.
package lbs2d_pkg;

   localparam int JOINT_COUNT     = 64;
   localparam int COEFS_PER_JOINT = 6;
   localparam int TABLE_DEPTH     = JOINT_COUNT * COEFS_PER_JOINT;
   localparam int TABLE_AW        = $clog2(TABLE_DEPTH);
   localparam int COEF_W          = 32;

   // request tdata layout, lowest bit first
   localparam int REQ_DATA_W     = 192;
   localparam int JOINT_LSB      = 0;
   localparam int JOINT_W        = 6;
   localparam int COEF_IDX_LSB   = 6;
   localparam int COEF_IDX_W     = 3;
   localparam int COEF_VAL_LSB   = 9;
   localparam int BIND_X_LSB     = 41;
   localparam int BIND_Y_LSB     = 73;
   localparam int DEFORM_X_LSB   = 105;
   localparam int DEFORM_Y_LSB   = 137;
   localparam int WEIGHT_LSB     = 169;
   localparam int WEIGHT_W       = 17;

   localparam int RSP_DATA_W     = 64;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

   // tuser kind codes on the request side
   localparam logic REQ_LOAD      = 1'b0;
   localparam logic REQ_INFLUENCE = 1'b1;

   localparam int              STEP_W    = 4;
   localparam logic [STEP_W-1:0] STEP_LAST = 4'd12;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_EMIT
   } state_type;

endpackage

/* sv/lbs2d_coef_ram.sv */
// Joint matrix coefficient store: one write port, one registered read port.
// Depends on lbs2d_pkg for depth, address width and data width.
module lbs2d_coef_ram (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [lbs2d_pkg::TABLE_AW-1:0]   wr_addr,
   input  logic [lbs2d_pkg::COEF_W-1:0]     wr_data,
   input  logic [lbs2d_pkg::TABLE_AW-1:0]   rd_addr,
   output logic [lbs2d_pkg::COEF_W-1:0]     rd_data
);

   logic [lbs2d_pkg::COEF_W-1:0] mem [0:lbs2d_pkg::TABLE_DEPTH-1];
   logic [lbs2d_pkg::COEF_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/linear_blend_skinning_2d_top.sv */
// 2D linear blend skinning engine, top level. Uses lbs2d_pkg and lbs2d_coef_ram.
// Load transaction: accepted while idle, ready again the next cycle.
// Influence transaction: stepped through one shared 33x33 multiplier (eight
//   products), then ready again; on the last influence the emit state loads the
//   result register, and stalls there while an earlier result, not yet taken, still
//   waits in the result register.
// Reset (synchronous, active high) clears sequencer, accumulators and rsp_tvalid;
//   the coefficient table is not cleared.
module linear_blend_skinning_2d_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // joint_index, coef_index, coef_value, bind_x, bind_y, deform_x, deform_y,
   // weight, zero pad
   input  logic [lbs2d_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                                req_tuser,   // req_type
   input  logic                                req_tlast,   // last_influence
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lbs2d_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // skinned_x, skinned_y
   output logic                                rsp_tuser    // saturated
);

   localparam int AW = lbs2d_pkg::TABLE_AW;

   function automatic logic [47:0] clamp48(input logic [49:0] v);
      logic [47:0] r;
      if (v[49:47] == 3'b000 || v[49:47] == 3'b111) begin
         r = v[47:0];
      end else if (v[49]) begin
         r = {1'b1, 47'd0};
      end else begin
         r = {1'b0, {47{1'b1}}};
      end
      return r;
   endfunction

   function automatic logic [31:0] clamp32_sum(input logic [32:0] v);
      logic [31:0] r;
      if (v[32] == v[31]) begin
         r = v[31:0];
      end else if (v[32]) begin
         r = {1'b1, 31'd0};
      end else begin
         r = {1'b0, {31{1'b1}}};
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- fields
   logic [lbs2d_pkg::JOINT_W-1:0]    joint;
   logic [lbs2d_pkg::COEF_IDX_W-1:0] coef_idx;
   logic [31:0]                      coef_val;
   logic [31:0]                      bind_x, bind_y, deform_x, deform_y;
   logic [lbs2d_pkg::WEIGHT_W-1:0]   weight;

   assign joint    = req_tdata[lbs2d_pkg::JOINT_LSB +: lbs2d_pkg::JOINT_W];
   assign coef_idx = req_tdata[lbs2d_pkg::COEF_IDX_LSB +: lbs2d_pkg::COEF_IDX_W];
   assign coef_val = req_tdata[lbs2d_pkg::COEF_VAL_LSB +: 32];
   assign bind_x   = req_tdata[lbs2d_pkg::BIND_X_LSB +: 32];
   assign bind_y   = req_tdata[lbs2d_pkg::BIND_Y_LSB +: 32];
   assign deform_x = req_tdata[lbs2d_pkg::DEFORM_X_LSB +: 32];
   assign deform_y = req_tdata[lbs2d_pkg::DEFORM_Y_LSB +: 32];
   assign weight   = req_tdata[lbs2d_pkg::WEIGHT_LSB +: lbs2d_pkg::WEIGHT_W];

   logic           joint_ok, coef_ok;
   logic [AW-1:0]  joint_base;
   logic [32:0]    sum_vx, sum_vy;

   assign joint_ok   = (32'(joint) < 32'(lbs2d_pkg::JOINT_COUNT));
   assign coef_ok    = (coef_idx < lbs2d_pkg::COEF_IDX_W'(lbs2d_pkg::COEFS_PER_JOINT));
   assign joint_base = AW'(joint) * AW'(lbs2d_pkg::COEFS_PER_JOINT);
   assign sum_vx     = {bind_x[31], bind_x} + {deform_x[31], deform_x};
   assign sum_vy     = {bind_y[31], bind_y} + {deform_y[31], deform_y};

   // ---------------------------------------------------------------- state
   lbs2d_pkg::state_type state_ff, state_in;

   logic [lbs2d_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [31:0]                    vx_ff, vx_in, vy_ff, vy_in;
   logic [lbs2d_pkg::WEIGHT_W-1:0] w_ff, w_in;
   logic                           last_ff, last_in;
   logic                           zero_m_ff, zero_m_in;
   logic [AW-1:0]                  base_ff, base_in;
   logic signed [65:0]             prod_ff, prod_in;
   logic [49:0]                    tx_ff, tx_in, ty_ff, ty_in;
   logic [49:0]                    bx_ff, bx_in, by_ff, by_in;
   logic [47:0]                    sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [31:0]                    rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic                           rsp_sat_ff, rsp_sat_in;

   logic              req_acc, emit_fire;
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr, ram_rd_addr;
   logic [31:0]       ram_rd_data, coef_s;
   logic signed [32:0] mul_a, mul_b;
   logic [49:0]       prod_shr;
   logic              ok_x, ok_y;

   assign req_acc  = req_tvalid && req_tready;
   assign coef_s   = zero_m_ff ? 32'd0 : ram_rd_data;
   assign prod_shr = prod_ff[65:16];   // floor shift by 16
   assign ok_x     = (sum_x_ff[47:31] == {17{sum_x_ff[47]}});
   assign ok_y     = (sum_y_ff[47:31] == {17{sum_y_ff[47]}});

   lbs2d_coef_ram u_coef_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (coef_val),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lbs2d_pkg::ST_IDLE: begin
            if (req_acc && req_tuser == lbs2d_pkg::REQ_INFLUENCE) begin
               state_in = lbs2d_pkg::ST_RUN;
            end
         end
         lbs2d_pkg::ST_RUN: begin
            if (step_ff == lbs2d_pkg::STEP_LAST) begin
               state_in = last_ff ? lbs2d_pkg::ST_EMIT : lbs2d_pkg::ST_IDLE;
            end
         end
         lbs2d_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = lbs2d_pkg::ST_IDLE;
            end
         end
         default: state_in = lbs2d_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- control outputs
   always_comb begin
      req_tready  = 1'b0;
      emit_fire   = 1'b0;
      ram_rd_addr = base_ff;
      case (state_ff)
         lbs2d_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         lbs2d_pkg::ST_RUN: begin
            // coefficients m0..m5 are fetched in order on steps 0..5
            if (32'(step_ff) < 32'(lbs2d_pkg::COEFS_PER_JOINT)) begin
               ram_rd_addr = base_ff + AW'(step_ff);
            end
         end
         lbs2d_pkg::ST_EMIT: begin
            emit_fire = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
      ram_wr_en   = req_acc && req_tuser == lbs2d_pkg::REQ_LOAD && joint_ok && coef_ok;
      ram_wr_addr = joint_base + AW'(coef_idx);
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      step_in   = step_ff;
      vx_in     = vx_ff;
      vy_in     = vy_ff;
      w_in      = w_ff;
      last_in   = last_ff;
      zero_m_in = zero_m_ff;
      base_in   = base_ff;
      tx_in     = tx_ff;
      ty_in     = ty_ff;
      bx_in     = bx_ff;
      by_in     = by_ff;
      sum_x_in  = sum_x_ff;
      sum_y_in  = sum_y_ff;
      mul_a     = '0;
      mul_b     = '0;

      if (state_ff == lbs2d_pkg::ST_IDLE) begin
         step_in   = '0;
         vx_in     = clamp32_sum(sum_vx);
         vy_in     = clamp32_sum(sum_vy);
         w_in      = (weight > lbs2d_pkg::WEIGHT_ONE) ? lbs2d_pkg::WEIGHT_ONE : weight;
         last_in   = req_tlast;
         zero_m_in = !joint_ok;
         base_in   = joint_ok ? joint_base : '0;
      end

      if (state_ff == lbs2d_pkg::ST_RUN) begin
         step_in = step_ff + 1'b1;
         case (step_ff)
            4'd1: begin
               mul_a = {vx_ff[31], vx_ff};
               mul_b = {coef_s[31], coef_s};
            end
            4'd2: begin
               mul_a = {vx_ff[31], vx_ff};
               mul_b = {coef_s[31], coef_s};
               tx_in = prod_shr;
            end
            4'd3: begin
               mul_a = {vy_ff[31], vy_ff};
               mul_b = {coef_s[31], coef_s};
               ty_in = prod_shr;
            end
            4'd4: begin
               mul_a = {vy_ff[31], vy_ff};
               mul_b = {coef_s[31], coef_s};
               tx_in = tx_ff + prod_shr;
            end
            4'd5: begin
               ty_in = ty_ff + prod_shr;
               tx_in = tx_ff + {{18{coef_s[31]}}, coef_s};
            end
            4'd6: begin
               ty_in = ty_ff + {{18{coef_s[31]}}, coef_s};
               tx_in = {{2{tx_ff[49]}}, clamp48(tx_ff)};
            end
            4'd7: begin
               ty_in = {{2{ty_ff[49]}}, clamp48(ty_ff)};
               mul_a = tx_ff[48:16];
               mul_b = {16'd0, w_ff};
            end
            4'd8: begin
               mul_a = ty_ff[48:16];
               mul_b = {16'd0, w_ff};
               bx_in = prod_ff[49:0];
            end
            // low half of the point times weight, split to keep the multiplier narrow
            4'd9: begin
               mul_a = {17'd0, tx_ff[15:0]};
               mul_b = {16'd0, w_ff};
               by_in = prod_ff[49:0];
            end
            4'd10: begin
               mul_a = {17'd0, ty_ff[15:0]};
               mul_b = {16'd0, w_ff};
               bx_in = bx_ff + prod_shr;
            end
            4'd11: begin
               by_in    = by_ff + prod_shr;
               sum_x_in = clamp48({{2{sum_x_ff[47]}}, sum_x_ff} + bx_ff);
            end
            4'd12: begin
               sum_y_in = clamp48({{2{sum_y_ff[47]}}, sum_y_ff} + by_ff);
            end
            default: begin
               mul_a = '0;
            end
         endcase
      end

      if (emit_fire) begin
         sum_x_in = '0;
         sum_y_in = '0;
      end
   end

   assign prod_in = mul_a * mul_b;

   // ---------------------------------------------------------------- result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_sat_in   = rsp_sat_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = ok_x ? sum_x_ff[31:0]
                             : (sum_x_ff[47] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}});
         rsp_y_in     = ok_y ? sum_y_ff[31:0]
                             : (sum_y_ff[47] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}});
         rsp_sat_in   = !(ok_x && ok_y);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lbs2d_pkg::ST_IDLE;
         step_ff      <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      vx_ff     <= vx_in;
      vy_ff     <= vy_in;
      w_ff      <= w_in;
      last_ff   <= last_in;
      zero_m_ff <= zero_m_in;
      base_ff   <= base_in;
      prod_ff   <= prod_in;
      tx_ff     <= tx_in;
      ty_ff     <= ty_in;
      bx_ff     <= bx_in;
      by_ff     <= by_in;
      rsp_x_ff  <= rsp_x_in;
      rsp_y_ff  <= rsp_y_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_sat_ff;

   // ---------------------------------------------------------------- assertions
   a_influence_starts: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tuser == lbs2d_pkg::REQ_INFLUENCE)
         |=> (state_ff == lbs2d_pkg::ST_RUN && step_ff == '0))
      else $error("influence transaction did not start the sequencer at step 0");

   a_load_single_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tuser == lbs2d_pkg::REQ_LOAD) |=> state_ff == lbs2d_pkg::ST_IDLE)
      else $error("load transaction left the engine busy");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      emit_fire |=> (rsp_tvalid && sum_x_ff == '0 && sum_y_ff == '0))
      else $error("result issued without clearing the accumulators");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == lbs2d_pkg::ST_RUN |-> step_ff <= lbs2d_pkg::STEP_LAST)
      else $error("sequencer step ran past the last step");

   a_write_idle_only: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> !$past(state_ff != lbs2d_pkg::ST_IDLE))
      else $error("coefficient write outside idle");

endmodule
